// ===== hdl/double_hash_open_address_table_macros.svh =====
// Assertion helpers for the hash table block.
`ifndef DOUBLE_HASH_OPEN_ADDRESS_TABLE_MACROS_SVH
`define DOUBLE_HASH_OPEN_ADDRESS_TABLE_MACROS_SVH
`ifndef SYNTH
`define DHOAT_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("dhoat assertion failed");
`define DHOAT_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("dhoat assertion failed");
`else
`define DHOAT_ASSERT(label, clk, rst, prop)
`define DHOAT_ASSERT_NEXT(label, clk, rst, cond, prop)
`endif
`endif

// ===== hdl/dhoat_pkg.sv =====
package dhoat_pkg;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_DELETE = 2'd1;
  localparam logic [1:0] ACT_FIND   = 2'd2;
  localparam logic [1:0] ACT_CLEAR  = 2'd3;

  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_OVERLOAD = 2'd1;
  localparam logic [1:0] ST_NO_FREE  = 2'd2;
  localparam logic [1:0] ST_MISSING  = 2'd3;

  localparam logic [1:0] MARK_EMPTY = 2'd0;
  localparam logic [1:0] MARK_USED  = 2'd1;
  localparam logic [1:0] MARK_GONE  = 2'd2;

  localparam logic CFG_TABLE_SIZE = 1'b0;
  localparam logic CFG_LOAD_LIMIT = 1'b1;

  localparam int SLOT_BITS = 10;
  localparam int COUNT_BITS = 11;
  localparam int SIZE_BITS = 11;
  localparam int LIMIT_BITS = 8;

  typedef struct packed {
    logic start;
    logic advance;
  } probe_cmd_t;

endpackage

// ===== hdl/dhoat_cell_ram.sv =====
module dhoat_cell_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 34
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/dhoat_probe.sv =====
module dhoat_probe #(
  parameter int CELLS = 1024,
  parameter int HASH_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  dhoat_pkg::probe_cmd_t        cmd,
  input  logic [HASH_BITS-1:0]         h1,
  input  logic [HASH_BITS-1:0]         h2,
  input  logic [$clog2(CELLS+1)-1:0]   n,
  output logic                         busy,
  output logic [$clog2(CELLS)-1:0]     addr
);

  localparam int AW = $clog2(CELLS);
  localparam int EW = $clog2(CELLS+1);
  localparam int HIW = $clog2(HASH_BITS);

  logic [EW-1:0]  rem1;
  logic [EW-1:0]  rem2;
  logic [HIW-1:0] bit_idx;
  logic [EW:0]    sh1;
  logic [EW:0]    sh2;
  logic [EW:0]    sum;
  logic [EW:0]    n_ext;

  assign n_ext = {1'b0, n};
  assign sh1 = {rem1, h1[bit_idx]};
  assign sh2 = {rem2, h2[bit_idx]};
  assign sum = {1'b0, rem1} + {1'b0, rem2};
  assign addr = rem1[AW-1:0];

  // restoring remainder, one hash bit per cycle from the top down
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      bit_idx <= '0;
    end else if (cmd.start) begin
      busy <= 1'b1;
      rem1 <= '0;
      rem2 <= '0;
      bit_idx <= HIW'(HASH_BITS - 1);
    end else if (busy) begin
      rem1 <= (sh1 >= n_ext) ? EW'(sh1 - n_ext) : EW'(sh1);
      rem2 <= (sh2 >= n_ext) ? EW'(sh2 - n_ext) : EW'(sh2);
      if (bit_idx == '0) begin
        busy <= 1'b0;
      end else begin
        bit_idx <= bit_idx - 1'b1;
      end
    end else if (cmd.advance) begin
      rem1 <= (sum >= n_ext) ? EW'(sum - n_ext) : EW'(sum);
    end
  end

endmodule

// ===== hdl/double_hash_open_address_table.sv =====
// Open-addressed hash table with double hashing.
// Requests enter on s_axis: tuser is the action (insert, delete, find,
// clear), tdata carries key, first hash and second hash. One result per
// request leaves on m_axis: tuser is the status, tdata the slot and the
// occupied count after the request. The user must issue cfg writes of
// table_size (index 0) and load_limit (index 1) only while the block is
// idle; the block does not enforce it. cfg_ready is always high. An insert
// refused for load goes straight to the hold state, which loads the output
// register. Other searches reduce both hashes modulo the table size, then
// read the memory and compare for each probe, and then load the result.
// Clear sweeps all CELLS cells, one per cycle, then returns its result.
// Reset runs the same sweep with s_axis_tready low.
// One request is worked at a time. A finished result waits in the output
// register while the next request is accepted; if a second result is ready
// before the first is taken, the block holds until m_axis_tready.
module double_hash_open_address_table #(
  parameter int CELLS = 1024,
  parameter int KEY_BITS = 32,
  parameter int HASH_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // key, first_hash, second_hash
  input  logic [((KEY_BITS+2*HASH_BITS+7)/8)*8-1:0] s_axis_tdata,
  // action
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // slot_index, occupied_count
  output logic [23:0] m_axis_tdata,
  // status
  output logic [1:0]  m_axis_tuser,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [10:0] cfg_data
);

  `include "double_hash_open_address_table_macros.svh"

  localparam int AW = $clog2(CELLS);
  localparam int EW = $clog2(CELLS+1);
  localparam int LW = EW + 9;
  localparam int MW = KEY_BITS + 2;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_MOD, S_READ, S_CHECK, S_HOLD
  } state_t;

  state_t state;
  logic [AW-1:0] sweep;
  logic clr_result;
  logic [1:0] act;
  logic [KEY_BITS-1:0] key_r;
  logic [HASH_BITS-1:0] h1;
  logic [HASH_BITS-1:0] h2;
  logic [EW-1:0] occ;
  logic [EW-1:0] pcnt;
  logic [dhoat_pkg::SIZE_BITS-1:0] tsize;
  logic [dhoat_pkg::LIMIT_BITS-1:0] limit;
  logic [1:0] res_status;
  logic [AW-1:0] res_slot;
  logic [1:0] out_status;
  logic [AW-1:0] out_slot;
  logic [EW-1:0] out_occ;

  logic [EW-1:0] n;
  logic overload;
  logic accept;
  logic [KEY_BITS-1:0] in_key;
  logic [1:0] rd_mark;
  logic [KEY_BITS-1:0] rd_key;
  logic last_probe;
  logic hit;

  dhoat_pkg::probe_cmd_t pcmd;
  logic p_busy;
  logic [AW-1:0] p_addr;

  logic mem_we;
  logic [AW-1:0] mem_waddr;
  logic [MW-1:0] mem_wdata;
  logic [MW-1:0] mem_rdata;

  always_comb begin
    if (tsize == '0) begin
      n = EW'(1);
    end else if (32'(tsize) > 32'(CELLS)) begin
      n = EW'(CELLS);
    end else begin
      n = EW'(tsize);
    end
  end

  assign overload = (LW'({{1'b0, occ} + 1'b1, 8'h00})) > (LW'(limit) * LW'(n));
  assign accept = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_key = s_axis_tdata[KEY_BITS-1:0];
  assign rd_mark = mem_rdata[MW-1:KEY_BITS];
  assign rd_key = mem_rdata[KEY_BITS-1:0];
  assign last_probe = ({1'b0, pcnt} + 1'b1) == {1'b0, n};
  assign hit = (act == dhoat_pkg::ACT_INSERT) ? (rd_mark != dhoat_pkg::MARK_USED)
             : (rd_mark == dhoat_pkg::MARK_USED && rd_key == key_r);

  always_comb begin
    pcmd.start = accept && s_axis_tuser != dhoat_pkg::ACT_CLEAR && !(
                 s_axis_tuser == dhoat_pkg::ACT_INSERT && overload);
    pcmd.advance = (state == S_CHECK) && !hit && !last_probe;
  end

  always_comb begin
    mem_we = 1'b0;
    mem_waddr = p_addr;
    mem_wdata = {dhoat_pkg::MARK_USED, key_r};
    if (state == S_CLEAR) begin
      mem_we = 1'b1;
      mem_waddr = sweep;
      mem_wdata = {dhoat_pkg::MARK_EMPTY, key_r};
    end else if (state == S_CHECK && hit && act != dhoat_pkg::ACT_FIND) begin
      mem_we = 1'b1;
      mem_wdata = {(act == dhoat_pkg::ACT_INSERT) ? dhoat_pkg::MARK_USED
                                                  : dhoat_pkg::MARK_GONE, key_r};
    end
  end

  dhoat_probe #(.CELLS(CELLS), .HASH_BITS(HASH_BITS)) u_probe (
    .clk(clk), .rst(rst), .cmd(pcmd), .h1(h1), .h2(h2), .n(n),
    .busy(p_busy), .addr(p_addr)
  );

  dhoat_cell_ram #(.DEPTH(CELLS), .WIDTH(MW)) u_ram (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(p_addr), .rdata(mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      tsize <= 11'd1024;
      limit <= 8'd192;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        dhoat_pkg::CFG_TABLE_SIZE: tsize <= cfg_data;
        dhoat_pkg::CFG_LOAD_LIMIT: limit <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      sweep <= '0;
      clr_result <= 1'b0;
      occ <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // drop the taken result unless a new one is loaded below
      if (m_axis_tvalid && m_axis_tready && state != S_HOLD) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          sweep <= sweep + 1'b1;
          if (sweep == AW'(CELLS - 1)) begin
            res_status <= dhoat_pkg::ST_DONE;
            res_slot <= '0;
            state <= clr_result ? S_HOLD : S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            act <= s_axis_tuser;
            key_r <= in_key;
            h1 <= s_axis_tdata[KEY_BITS +: HASH_BITS];
            h2 <= s_axis_tdata[KEY_BITS+HASH_BITS +: HASH_BITS];
            pcnt <= '0;
            res_slot <= '0;
            if (s_axis_tuser == dhoat_pkg::ACT_CLEAR) begin
              occ <= '0;
              sweep <= '0;
              clr_result <= 1'b1;
              state <= S_CLEAR;
            end else if (s_axis_tuser == dhoat_pkg::ACT_INSERT && overload) begin
              res_status <= dhoat_pkg::ST_OVERLOAD;
              state <= S_HOLD;
            end else begin
              state <= S_MOD;
            end
          end
        end
        S_MOD: begin
          if (!p_busy) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (hit) begin
            res_status <= dhoat_pkg::ST_DONE;
            res_slot <= p_addr;
            if (act == dhoat_pkg::ACT_INSERT) begin
              occ <= occ + 1'b1;
            end else if (act == dhoat_pkg::ACT_DELETE) begin
              occ <= occ - 1'b1;
            end
            state <= S_HOLD;
          end else if (last_probe) begin
            res_status <= (act == dhoat_pkg::ACT_INSERT) ? dhoat_pkg::ST_NO_FREE
                                                         : dhoat_pkg::ST_MISSING;
            state <= S_HOLD;
          end else begin
            pcnt <= pcnt + 1'b1;
            state <= S_READ;
          end
        end
        S_HOLD: begin
          // load the output register once it is free or being drained
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            out_status <= res_status;
            out_slot <= res_slot;
            out_occ <= occ;
            clr_result <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tuser = out_status;
  assign m_axis_tdata = {3'b000, dhoat_pkg::COUNT_BITS'(out_occ),
                         dhoat_pkg::SLOT_BITS'(out_slot)};

  `DHOAT_ASSERT(a_occ_bound, clk, rst, 32'(occ) <= 32'(CELLS))
  `DHOAT_ASSERT(a_probe_bound, clk, rst, state != S_CHECK || pcnt < n)
  `DHOAT_ASSERT(a_write_phase, clk, rst,
    !mem_we || state == S_CLEAR || state == S_CHECK)
  `DHOAT_ASSERT_NEXT(a_hold_loads, clk, rst,
    state == S_HOLD && (!m_axis_tvalid || m_axis_tready), m_axis_tvalid)

endmodule

// ===== tb/sv/tb_double_hash_open_address_table.sv =====
`timescale 1ns / 1ps

module tb_double_hash_open_address_table;

  localparam int NCELLS = 1024;
  localparam int CYCLE_LIMIT = 20000000;

  typedef struct {
    logic [1:0]  act;
    logic [31:0] key;
    logic [15:0] h1;
    logic [15:0] h2;
  } request_t;

  typedef struct {
    logic [1:0]                       status;
    logic [dhoat_pkg::SLOT_BITS-1:0]  slot;
    logic [dhoat_pkg::COUNT_BITS-1:0] occ;
  } outcome_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [10:0] cfg_data = '0;

  double_hash_open_address_table u_top (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  request_t pending_requests[$];
  outcome_t expected_outcomes[$];
  int mismatches = 0;
  int cycles = 0;
  bit quiet = 1'b0;
  logic hold_kick = 1'b0;

  // Shadow table
  logic [31:0] shadow_keys[NCELLS];
  logic [1:0]  shadow_marks[NCELLS];
  int unsigned shadow_occ = 0;
  int unsigned shadow_size = 1024;
  int unsigned shadow_limit = 192;

  function automatic int unsigned active_size();
    if (shadow_size == 0) return 1;
    if (shadow_size > NCELLS) return NCELLS;
    return shadow_size;
  endfunction

  task automatic apply_request(input logic [1:0] act, input logic [31:0] key,
                               input logic [15:0] h1, input logic [15:0] h2);
    int unsigned n;
    longint unsigned c;
    outcome_t r;
    n = active_size();
    r.status = dhoat_pkg::ST_DONE;
    r.slot = '0;
    if (act == dhoat_pkg::ACT_CLEAR) begin
      for (int j = 0; j < NCELLS; j++) shadow_marks[j] = dhoat_pkg::MARK_EMPTY;
      shadow_occ = 0;
    end else if (act == dhoat_pkg::ACT_INSERT) begin
      if (longint'(shadow_occ + 1) * 256 > longint'(shadow_limit) * n) begin
        r.status = dhoat_pkg::ST_OVERLOAD;
      end else begin
        r.status = dhoat_pkg::ST_NO_FREE;
        for (int unsigned i = 0; i < n; i++) begin
          c = (longint'(h1) + longint'(h2) * i) % n;
          if (shadow_marks[c] != dhoat_pkg::MARK_USED) begin
            shadow_keys[c] = key;
            shadow_marks[c] = dhoat_pkg::MARK_USED;
            shadow_occ++;
            r.status = dhoat_pkg::ST_DONE;
            r.slot = c[dhoat_pkg::SLOT_BITS-1:0];
            break;
          end
        end
      end
    end else begin
      r.status = dhoat_pkg::ST_MISSING;
      for (int unsigned i = 0; i < n; i++) begin
        c = (longint'(h1) + longint'(h2) * i) % n;
        if (shadow_marks[c] == dhoat_pkg::MARK_USED && shadow_keys[c] == key) begin
          if (act == dhoat_pkg::ACT_DELETE) begin
            shadow_marks[c] = dhoat_pkg::MARK_GONE;
            shadow_occ--;
          end
          r.status = dhoat_pkg::ST_DONE;
          r.slot = c[dhoat_pkg::SLOT_BITS-1:0];
          break;
        end
      end
    end
    r.occ = shadow_occ[dhoat_pkg::COUNT_BITS-1:0];
    expected_outcomes.push_back(r);
  endtask

  initial begin
    for (int j = 0; j < NCELLS; j++) begin
      shadow_marks[j] = dhoat_pkg::MARK_EMPTY;
      shadow_keys[j] = '0;
    end
  end

  // Predict on accepted requests and register writes
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == dhoat_pkg::CFG_TABLE_SIZE) shadow_size = cfg_data;
        else shadow_limit = cfg_data[7:0];
      end
      if (s_axis_tvalid && s_axis_tready)
        apply_request(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[47:32],
                      s_axis_tdata[63:48]);
    end
  end

  // Request driver
  int send_gap = 0;
  always @(posedge clk) begin
    request_t q;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pending_requests.size() > 0) begin
        q = pending_requests.pop_front();
        s_axis_tuser <= q.act;
        s_axis_tdata <= {q.h2, q.h1, q.key};
        s_axis_tvalid <= 1'b1;
        if (!quiet && $urandom_range(0, 7) == 0) send_gap <= $urandom_range(1, 7);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result side backpressure
  int hold_left = 0;
  int stall_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_kick) begin
      hold_left <= 400;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 6);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Result checker
  always @(posedge clk) begin
    outcome_t e;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_outcomes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status %0d slot %0d occ %0d",
                   m_axis_tuser, m_axis_tdata[9:0], m_axis_tdata[20:10]);
      end else begin
        e = expected_outcomes.pop_front();
        if (m_axis_tuser !== e.status || m_axis_tdata[9:0] !== e.slot ||
            m_axis_tdata[20:10] !== e.occ) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected status %0d slot %0d occ %0d, got %0d %0d %0d",
                     e.status, e.slot, e.occ,
                     m_axis_tuser, m_axis_tdata[9:0], m_axis_tdata[20:10]);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("double_hash_open_address_table test failed");
      $finish;
    end
  end

  task automatic write_reg(input logic idx, input logic [10:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // sample away from the rising edge so driver updates have settled
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_requests.size() > 0 || s_axis_tvalid || expected_outcomes.size() > 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic push_req(input logic [1:0] act, input logic [31:0] key,
                          input logic [15:0] h1, input logic [15:0] h2);
    request_t q;
    q.act = act; q.key = key; q.h1 = h1; q.h2 = h2;
    pending_requests.push_back(q);
  endtask

  // Random requests drawn mostly from a small key pool so searches hit
  task automatic queue_random(input int count);
    request_t pool[16];
    int p, roll;
    logic [1:0] act;
    for (int j = 0; j < 16; j++) begin
      pool[j].key = $urandom;
      pool[j].h1 = 16'($urandom);
      case ($urandom_range(0, 3))
        0: pool[j].h2 = 16'd0;
        1: pool[j].h2 = 16'($urandom_range(1, 8));
        default: pool[j].h2 = 16'($urandom);
      endcase
    end
    for (int j = 0; j < count; j++) begin
      roll = $urandom_range(0, 99);
      if (roll < 40) act = dhoat_pkg::ACT_INSERT;
      else if (roll < 62) act = dhoat_pkg::ACT_DELETE;
      else if (roll < 98) act = dhoat_pkg::ACT_FIND;
      else act = dhoat_pkg::ACT_CLEAR;
      if ($urandom_range(0, 99) < 12) begin
        push_req(2'($urandom_range(0, 3)), $urandom, 16'($urandom), 16'($urandom));
      end else begin
        p = $urandom_range(0, 15);
        push_req(act, pool[p].key, pool[p].h1, pool[p].h2);
      end
    end
  endtask

  initial begin
    int sizes[12]  = '{1, 2, 4, 7, 16, 16, 64, 13, 1024, 32, 5, 24};
    int limits[12] = '{255, 255, 255, 200, 192, 1, 128, 255, 255, 255, 77, 255};
    int counts[12] = '{80, 100, 150, 150, 150, 100, 200, 150, 90, 200, 130, 150};
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes, every action, duplicates, delete leaves a gap
    push_req(dhoat_pkg::ACT_INSERT, 32'h0, 16'h0, 16'h0);
    push_req(dhoat_pkg::ACT_INSERT, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF);
    push_req(dhoat_pkg::ACT_FIND, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF);
    push_req(dhoat_pkg::ACT_INSERT, 32'h0, 16'h0, 16'h0);
    push_req(dhoat_pkg::ACT_DELETE, 32'h0, 16'h0, 16'h0);
    push_req(dhoat_pkg::ACT_FIND, 32'h0, 16'h0, 16'h0);
    push_req(dhoat_pkg::ACT_DELETE, 32'h0, 16'h0, 16'h0);
    push_req(dhoat_pkg::ACT_FIND, 32'h0, 16'h0, 16'h0);
    push_req(dhoat_pkg::ACT_CLEAR, 32'h0, 16'h0, 16'h0);
    push_req(dhoat_pkg::ACT_FIND, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF);
    wait_drained();

    // Step shares a factor with the size: only two cells reachable
    write_reg(dhoat_pkg::CFG_TABLE_SIZE, 11'd4);
    write_reg(dhoat_pkg::CFG_LOAD_LIMIT, 11'd255);
    push_req(dhoat_pkg::ACT_INSERT, 32'h11, 16'd1, 16'd2);
    push_req(dhoat_pkg::ACT_INSERT, 32'h22, 16'd1, 16'd2);
    push_req(dhoat_pkg::ACT_INSERT, 32'h33, 16'd1, 16'd2);
    push_req(dhoat_pkg::ACT_DELETE, 32'h11, 16'd1, 16'd2);
    push_req(dhoat_pkg::ACT_FIND, 32'h22, 16'd1, 16'd2);
    push_req(dhoat_pkg::ACT_INSERT, 32'h44, 16'd0, 16'd1);
    push_req(dhoat_pkg::ACT_INSERT, 32'h55, 16'd0, 16'd1);
    wait_drained();
    write_reg(dhoat_pkg::CFG_TABLE_SIZE, 11'd1);
    write_reg(dhoat_pkg::CFG_LOAD_LIMIT, 11'd1);
    push_req(dhoat_pkg::ACT_FIND, 32'h22, 16'd1, 16'd2);
    push_req(dhoat_pkg::ACT_INSERT, 32'h66, 16'd0, 16'd0);
    push_req(dhoat_pkg::ACT_CLEAR, 32'h0, 16'h0, 16'h0);
    wait_drained();

    for (int ph = 0; ph < 12; ph++) begin
      write_reg(dhoat_pkg::CFG_TABLE_SIZE, 11'(sizes[ph]));
      write_reg(dhoat_pkg::CFG_LOAD_LIMIT, 11'(limits[ph]));
      if (ph == 11) quiet = 1'b1;
      queue_random(counts[ph]);
      if (ph == 3) begin
        @(posedge clk);
        hold_kick <= 1'b1;
        @(posedge clk);
        hold_kick <= 1'b0;
      end
      wait_drained();
    end

    repeat (50) @(posedge clk);
    if (mismatches == 0 && expected_outcomes.size() == 0)
      $display("double_hash_open_address_table test passed");
    else
      $display("double_hash_open_address_table test failed");
    $finish;
  end

endmodule
